### rtl/kard_pkg.sv
// Shared types, constants and the key mapping table for the auto shift detector.
// No dependencies; every module of the block imports this package.
package kard_pkg;

	localparam int KEY_SLOTS = 256;
	localparam int SLOT_W = $clog2(KEY_SLOTS);
	localparam int CNT_W = 7;
	localparam int CODE_W = 7;
	localparam int IDX_W = 1;
	localparam int DATA_W = 7;

	localparam logic [IDX_W-1:0] REG_ENABLE = 1'b0;
	localparam logic [IDX_W-1:0] REG_MIN_REPEAT = 1'b1;

	localparam logic [CNT_W-1:0] REPEAT_LOW = 7'd2;
	localparam logic [CNT_W-1:0] REPEAT_HIGH = 7'd100;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic key_down;
		logic modifier_held;
		logic ime_hangul;
		logic injected;
		logic [7:0] scan_code;
		logic [7:0] key_code;
	} event_t;

	typedef struct packed {
		logic suppress;
		logic send_backspace;
		logic send_char;
		logic [CODE_W-1:0] char_code;
	} result_t;

	typedef struct packed {
		logic en;
		slot_t slot;
		cnt_t cnt;
	} wb_t;

	function automatic slot_t slot_of(input logic [7:0] scan);
		return SLOT_W'(scan % KEY_SLOTS);
	endfunction

	// Shifted character of a virtual key, zero when the key has none
	function automatic logic [CODE_W-1:0] shifted_of(input logic [7:0] vk);
		logic [CODE_W-1:0] ch;
		ch = '0;
		if (vk >= 8'h41 && vk <= 8'h5A) begin
			ch = vk[CODE_W-1:0];
		end else begin
			unique case (vk)
				8'hC0: ch = 7'h7E;
				8'h31: ch = 7'h21;
				8'h32: ch = 7'h40;
				8'h33: ch = 7'h23;
				8'h34: ch = 7'h24;
				8'h35: ch = 7'h25;
				8'h36: ch = 7'h5E;
				8'h37: ch = 7'h26;
				8'h38: ch = 7'h2A;
				8'h39: ch = 7'h28;
				8'h30: ch = 7'h29;
				8'hBD: ch = 7'h5F;
				8'hBB: ch = 7'h2B;
				8'hDB: ch = 7'h7B;
				8'hDD: ch = 7'h7D;
				8'hDC: ch = 7'h7C;
				8'hBA: ch = 7'h3A;
				8'hDE: ch = 7'h22;
				8'hBC: ch = 7'h3C;
				8'hBE: ch = 7'h3E;
				8'hBF: ch = 7'h3F;
				default: ch = '0;
			endcase
		end
		return ch;
	endfunction

endpackage

### rtl/kard_cnt_mem.sv
// Repeat counter store: one synchronous memory entry per scan code slot.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// Depends on kard_pkg.
module kard_cnt_mem (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  kard_pkg::slot_t rd_slot,
	output kard_pkg::cnt_t  rd_cnt,
	input  kard_pkg::wb_t   wb
);
	import kard_pkg::*;

	cnt_t mem [KEY_SLOTS];
	logic [KEY_SLOTS-1:0] vld_q;
	cnt_t rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wb.en) begin
			mem[wb.slot] <= wb.cnt;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wb.en) begin
				vld_q[wb.slot] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_slot];
			end
		end
	end

	assign rd_cnt = rd_vld_q ? rd_data_q : '0;

endmodule

### rtl/kard_step.sv
// Counter update and result decision for one key event.
// Combinational; depends on kard_pkg for the event, result and write-back types.
module kard_step (
	input  kard_pkg::event_t  ev,
	input  kard_pkg::cnt_t    cnt,
	input  logic              enable,
	input  logic [6:0]        min_repeat,
	output kard_pkg::result_t res,
	output logic              wr,
	output kard_pkg::cnt_t    wr_cnt
);
	import kard_pkg::*;

	cnt_t m;
	cnt_t c1;
	logic [CODE_W-1:0] ch;
	logic active;
	logic press;
	logic bs;
	logic sc;

	always_comb begin
		if (min_repeat < REPEAT_LOW) begin
			m = REPEAT_LOW;
		end else if (min_repeat > REPEAT_HIGH) begin
			m = REPEAT_HIGH;
		end else begin
			m = min_repeat;
		end
	end

	assign ch = shifted_of(ev.key_code);
	assign active = enable && !ev.injected && ev.scan_code != 8'd0;
	assign press = ev.key_down && !ev.modifier_held && !ev.ime_hangul;

	always_comb begin
		res = '0;
		wr = 1'b0;
		wr_cnt = '0;
		bs = 1'b0;
		sc = 1'b0;
		c1 = cnt;
		if (active) begin
			if (press) begin
				if (ch != '0) begin
					wr = 1'b1;
					if (cnt < m) begin
						wr_cnt = cnt + 7'd1;
					end else begin
						bs = (cnt == m);
						c1 = bs ? cnt + 7'd1 : cnt;
						sc = ({1'b0, c1} == {1'b0, m} + 8'd1);
						wr_cnt = sc ? c1 + 7'd1 : c1;
					end
					res.send_backspace = bs;
					res.send_char = sc;
					res.char_code = sc ? ch : '0;
					res.suppress = wr_cnt > 7'd1;
				end else begin
					res.suppress = cnt > 7'd1;
				end
			end else begin
				wr = 1'b1;
			end
		end
	end

endmodule

### rtl/key_autoshift_repeat_detector_core.sv
// Top level of the auto shift on hold detector: input stage, counter memory,
// update logic and output register. Depends on kard_pkg, kard_cnt_mem, kard_step.
//
// Usage:
//   Key events enter on the key channel (key_valid / key_stall) with one field
//   per port; one result per event leaves on the res channel (res_valid /
//   res_stall). A transfer happens at a rising edge with valid high and stall low.
//   An event transferred at an edge reads its counter at that edge, is updated in
//   the update stage and its result is registered in the output register once
//   that stage advances; res_valid is high from then until it is transferred.
//   Throughput is one event per cycle while res_stall is low; a counter write
//   and the next read share an edge, and a same-slot hit is forwarded.
//   While res_stall is high the result holds, one more event may wait in the
//   update stage, and key_stall rises once that stage is full.
//   Configuration: cfg_we with cfg_index 0 (enable) or 1 (min_repeat) writes
//   cfg_data; write only while no event is in flight.
//   Reset clears enable to 1, min_repeat to 2 and all 256 counter valid bits,
//   so every counter reads zero right after reset with no clearing pass.
module key_autoshift_repeat_detector_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        key_valid,
	output logic                        key_stall,
	input  logic                        key_down,
	input  logic                        modifier_held,
	input  logic                        ime_hangul,
	input  logic                        injected,
	input  logic [7:0]                  scan_code,
	input  logic [7:0]                  key_code,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        suppress,
	output logic                        send_backspace,
	output logic                        send_char,
	output logic [kard_pkg::CODE_W-1:0] char_code,
	input  logic                        cfg_we,
	input  logic [kard_pkg::IDX_W-1:0]  cfg_index,
	input  logic [kard_pkg::DATA_W-1:0] cfg_data
);
	import kard_pkg::*;

	logic enable_q;
	logic [6:0] min_repeat_q;

	logic vld_s1;
	event_t ev_s1;
	logic hit_s1;
	cnt_t fwd_s1;

	logic out_vld_q;
	result_t res_q;

	event_t ev_in;
	slot_t slot_in;
	logic accept;
	logic advance;
	cnt_t mem_cnt;
	cnt_t cnt_s1;
	result_t res_s1;
	logic wr_s1;
	cnt_t wr_cnt_s1;
	wb_t wb;

	assign ev_in = '{key_down: key_down, modifier_held: modifier_held,
		ime_hangul: ime_hangul, injected: injected,
		scan_code: scan_code, key_code: key_code};
	assign slot_in = slot_of(scan_code);

	assign advance = !out_vld_q || !res_stall;
	assign key_stall = vld_s1 && !advance;
	assign accept = key_valid && !key_stall;

	assign wb.en = vld_s1 && advance && wr_s1;
	assign wb.slot = slot_of(ev_s1.scan_code);
	assign wb.cnt = wr_cnt_s1;

	kard_cnt_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_slot (slot_in),
		.rd_cnt  (mem_cnt),
		.wb      (wb)
	);

	assign cnt_s1 = hit_s1 ? fwd_s1 : mem_cnt;

	kard_step u_step (
		.ev         (ev_s1),
		.cnt        (cnt_s1),
		.enable     (enable_q),
		.min_repeat (min_repeat_q),
		.res        (res_s1),
		.wr         (wr_s1),
		.wr_cnt     (wr_cnt_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			min_repeat_q <= 7'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:     enable_q <= cfg_data[0];
				REG_MIN_REPEAT: min_repeat_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev_in;
			hit_s1 <= wb.en && wb.slot == slot_in;
			fwd_s1 <= wb.cnt;
		end
		if (advance && vld_s1) begin
			res_q <= res_s1;
		end
	end

	assign res_valid = out_vld_q;
	assign suppress = res_q.suppress;
	assign send_backspace = res_q.send_backspace;
	assign send_char = res_q.send_char;
	assign char_code = res_q.char_code;

endmodule
